FILE: rtl/core/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// shared types, codes and sizes for the max-heap priority queue
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int DEF_CAPACITY = 64;

    // action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // compare unit selection codes
    localparam logic [1:0] PICK_KEEP = 2'd0;
    localparam logic [1:0] PICK_A    = 2'd1;
    localparam logic [1:0] PICK_B    = 2'd2;

    typedef logic [7:0]  prio_t;
    typedef logic [6:0]  count_t;

    typedef struct packed {
        prio_t       prio;
        logic [6:0]  age;
        logic [15:0] id;
    } entry_t;

    typedef struct packed {
        logic        action;
        prio_t       priority_req;
        logic [6:0]  age;
        logic [15:0] patient_id;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        prio_t       top_priority;
        logic [6:0]  top_age;
        logic [15:0] top_id;
        count_t      entry_count;
    } rsp_t;

endpackage

FILE: rtl/core/mhpq_store.sv
// ----------------------------------------------------------------------------
// mhpq_store
// heap entry memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
module mhpq_store #(
    parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  mhpq_pkg::entry_t  wr_data,
    input  logic [AW-1:0]     rd_addr_a,
    input  logic [AW-1:0]     rd_addr_b,
    output mhpq_pkg::entry_t  rd_data_a,
    output mhpq_pkg::entry_t  rd_data_b
);

    mhpq_pkg::entry_t mem [CAPACITY];
    mhpq_pkg::entry_t rd_a_reg;
    mhpq_pkg::entry_t rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

FILE: rtl/core/mhpq_cmp.sv
// ----------------------------------------------------------------------------
// mhpq_cmp
// shared priority compare unit: largest of base, a, b wins; a tie goes to base, then to a over b
// ----------------------------------------------------------------------------
module mhpq_cmp (
    input  mhpq_pkg::prio_t base,
    input  mhpq_pkg::prio_t cand_a,
    input  logic            cand_a_vld,
    input  mhpq_pkg::prio_t cand_b,
    input  logic            cand_b_vld,
    output logic [1:0]      pick
);

    mhpq_pkg::prio_t best;

    always_comb begin
        best = base;
        pick = mhpq_pkg::PICK_KEEP;
        if (cand_a_vld && (cand_a > best)) begin
            best = cand_a;
            pick = mhpq_pkg::PICK_A;
        end
        if (cand_b_vld && (cand_b > best)) begin
            pick = mhpq_pkg::PICK_B;
        end
    end

endmodule

FILE: rtl/core/mhpq_ctrl.sv
// ----------------------------------------------------------------------------
// mhpq_ctrl
// sift sequencer: walks the heap level by level (check or read state, then compare state) with a hole
// ----------------------------------------------------------------------------
module mhpq_ctrl #(
    parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    output logic             idle,
    input  mhpq_pkg::req_t   req,
    output logic             res_valid,
    input  logic             res_ready,
    output mhpq_pkg::rsp_t   res
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP_CHK = 3'd1;
    localparam logic [2:0] S_UP_CMP = 3'd2;
    localparam logic [2:0] S_DN_LD  = 3'd3;
    localparam logic [2:0] S_DN_RD  = 3'd4;
    localparam logic [2:0] S_DN_CMP = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [PW-1:0]     cnt_reg, cnt_next;
    logic [PW-1:0]     pos_reg, pos_next;
    mhpq_pkg::entry_t  item_reg, item_next;
    mhpq_pkg::entry_t  top_reg, top_next;
    logic [1:0]        status_reg, status_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    mhpq_pkg::entry_t  wr_data;
    logic [AW-1:0]     rd_addr_a;
    logic [AW-1:0]     rd_addr_b;
    mhpq_pkg::entry_t  rd_data_a;
    mhpq_pkg::entry_t  rd_data_b;

    mhpq_pkg::prio_t   cmp_base;
    mhpq_pkg::prio_t   cmp_a;
    mhpq_pkg::prio_t   cmp_b;
    logic              cmp_b_vld;
    logic [1:0]        cmp_pick;

    logic [PW:0]       left_pos;
    logic [PW:0]       right_pos;
    logic [PW-1:0]     parent_pos;
    logic [AW-1:0]     pos_addr;
    mhpq_pkg::entry_t  new_entry;

    assign left_pos   = {pos_reg, 1'b0};
    assign right_pos  = left_pos + 1'b1;
    assign parent_pos = pos_reg >> 1;
    assign pos_addr   = AW'(pos_reg - 1'b1);
    assign new_entry  = '{prio: req.priority_req, age: req.age, id: req.patient_id};

    mhpq_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // insert: parent is base, new entry is candidate a
    // remove: hole item is base, children are candidates a and b
    assign cmp_base  = (state_reg == S_UP_CMP) ? rd_data_a.prio : item_reg.prio;
    assign cmp_a     = (state_reg == S_UP_CMP) ? item_reg.prio : rd_data_a.prio;
    assign cmp_b     = rd_data_b.prio;
    assign cmp_b_vld = (state_reg == S_DN_CMP) && (right_pos <= {1'b0, cnt_reg});

    mhpq_cmp u_cmp (
        .base       (cmp_base),
        .cand_a     (cmp_a),
        .cand_a_vld (1'b1),
        .cand_b     (cmp_b),
        .cand_b_vld (cmp_b_vld),
        .pick       (cmp_pick)
    );

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        item_next   = item_reg;
        top_next    = top_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = pos_addr;
        wr_data     = item_reg;
        rd_addr_a   = AW'(parent_pos - 1'b1);
        rd_addr_b   = AW'(left_pos);

        unique case (state_reg)
            S_IDLE: begin
                rd_addr_a = '0;
                rd_addr_b = AW'(cnt_reg - 1'b1);
                if (start) begin
                    top_next    = '0;
                    status_next = mhpq_pkg::ST_OK;
                    if (req.action == mhpq_pkg::ACT_INSERT) begin
                        if (cnt_reg == PW'(CAPACITY)) begin
                            status_next = mhpq_pkg::ST_FULL;
                            state_next  = S_DONE;
                        end else begin
                            cnt_next   = cnt_reg + 1'b1;
                            pos_next   = cnt_reg + 1'b1;
                            item_next  = new_entry;
                            state_next = S_UP_CHK;
                        end
                    end else begin
                        if (cnt_reg == '0) begin
                            status_next = mhpq_pkg::ST_EMPTY;
                            state_next  = S_DONE;
                        end else begin
                            cnt_next   = cnt_reg - 1'b1;
                            pos_next   = PW'(1);
                            state_next = S_DN_LD;
                        end
                    end
                end
            end
            S_UP_CHK: begin
                if (pos_reg == PW'(1)) begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                wr_en = 1'b1;
                if (cmp_pick == mhpq_pkg::PICK_A) begin
                    wr_data    = rd_data_a;
                    pos_next   = parent_pos;
                    state_next = S_UP_CHK;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DN_LD: begin
                top_next  = rd_data_a;
                item_next = rd_data_b;
                if (cnt_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_DN_RD;
                end
            end
            S_DN_RD: begin
                rd_addr_a = AW'(left_pos - 1'b1);
                if (left_pos > {1'b0, cnt_reg}) begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                wr_en = 1'b1;
                unique case (cmp_pick)
                    mhpq_pkg::PICK_A: begin
                        wr_data    = rd_data_a;
                        pos_next   = PW'(left_pos);
                        state_next = S_DN_RD;
                    end
                    mhpq_pkg::PICK_B: begin
                        wr_data    = rd_data_b;
                        pos_next   = PW'(right_pos);
                        state_next = S_DN_RD;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        pos_reg    <= pos_next;
        item_reg   <= item_next;
        top_reg    <= top_next;
        status_reg <= status_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb begin
        res.status       = status_reg;
        res.top_priority = top_reg.prio;
        res.top_age      = top_reg.age;
        res.top_id       = top_reg.id;
        res.entry_count  = mhpq_pkg::count_t'(cnt_reg);
    end

endmodule

FILE: rtl/core/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// binary max-heap priority queue with insert and remove-top transactions
// ----------------------------------------------------------------------------
// s_ channel: one request per transaction, action selects insert or remove of
// the highest priority entry. m_ channel: one response per request with
// status, the removed entry (zero unless a remove succeeds) and the count.
// Each request is processed by a sequencer that moves a hole through the heap
// memory level by level (registered read, then compare and write through the
// single compare unit). Rejected requests (full or empty) go straight to the
// response without touching the heap. s_ready is high only while the
// sequencer is idle, from the cycle after the response enters the output
// register, so a new request is not taken before the last response has
// entered the output register. A stalled receiver holds the sequencer once a
// second response is ready. Reset empties the queue; the memory contents are
// not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  mhpq_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output mhpq_pkg::rsp_t  m_data
);

    logic            ctrl_idle;
    logic            res_valid;
    logic            res_ready;
    mhpq_pkg::rsp_t  res;
    logic            m_valid_reg, m_valid_next;
    mhpq_pkg::rsp_t  m_data_reg, m_data_next;

    mhpq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_valid),
        .idle      (ctrl_idle),
        .req       (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign s_ready   = ctrl_idle;
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sequencer stayed idle after an accepted transaction");

    a_idle_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_idle |-> !res_valid)
        else $error("result pending while sequencer idle");

    a_reject_zero_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != mhpq_pkg::ST_OK)) |->
        (m_data.top_priority == '0 && m_data.top_age == '0 && m_data.top_id == '0))
        else $error("rejected transaction returned a nonzero entry");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == mhpq_pkg::ST_EMPTY)) |-> (m_data.entry_count == '0))
        else $error("empty response with nonzero entry count");

endmodule

FILE: tb/max_heap_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue_tb
// self-checking bench for the max-heap priority queue: a scoreboard keeps its
// own heap, predicts every response from each accepted request and compares
// all response fields in order; stimulus is a directed opening followed by
// fill, drain and mixed phases under random idling on both channels
// ----------------------------------------------------------------------------
module max_heap_priority_queue_tb;

    localparam int CAP         = mhpq_pkg::DEF_CAPACITY;
    localparam int RAND_ITEMS  = 500;
    localparam int QUIET_AFTER = 440;
    localparam int CYCLE_LIMIT = 400000;

    class heap_scoreboard;
        mhpq_pkg::entry_t heap_mem [1:CAP];
        int unsigned      fill = 0;
        mhpq_pkg::rsp_t   expected_q [$];
        int unsigned      errors = 0;

        task report_mismatch(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // apply one accepted request to the heap copy and queue its response
        function void note_request(input mhpq_pkg::req_t r);
            mhpq_pkg::rsp_t   rsp;
            mhpq_pkg::entry_t tmp;
            int unsigned      k;
            int unsigned      best;
            bit               done;
            rsp = '0;
            if (r.action == mhpq_pkg::ACT_INSERT) begin
                if (fill >= CAP) begin
                    rsp.status = mhpq_pkg::ST_FULL;
                end else begin
                    fill++;
                    heap_mem[fill] = '{prio: r.priority_req, age: r.age, id: r.patient_id};
                    k = fill;
                    while (k > 1 && heap_mem[k / 2].prio < heap_mem[k].prio) begin
                        tmp = heap_mem[k / 2];
                        heap_mem[k / 2] = heap_mem[k];
                        heap_mem[k] = tmp;
                        k = k / 2;
                    end
                end
            end else begin
                if (fill == 0) begin
                    rsp.status = mhpq_pkg::ST_EMPTY;
                end else begin
                    rsp.top_priority = heap_mem[1].prio;
                    rsp.top_age = heap_mem[1].age;
                    rsp.top_id = heap_mem[1].id;
                    heap_mem[1] = heap_mem[fill];
                    fill--;
                    k = 1;
                    done = 1'b0;
                    while (!done) begin
                        best = k;
                        if (2 * k <= fill && heap_mem[2 * k].prio > heap_mem[best].prio)
                            best = 2 * k;
                        if (2 * k + 1 <= fill && heap_mem[2 * k + 1].prio > heap_mem[best].prio)
                            best = 2 * k + 1;
                        if (best == k) begin
                            done = 1'b1;
                        end else begin
                            tmp = heap_mem[k];
                            heap_mem[k] = heap_mem[best];
                            heap_mem[best] = tmp;
                            k = best;
                        end
                    end
                end
            end
            rsp.entry_count = mhpq_pkg::count_t'(fill);
            expected_q.push_back(rsp);
        endfunction

        task check_response(input mhpq_pkg::rsp_t got);
            mhpq_pkg::rsp_t exp;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected response %h", got));
            end else begin
                exp = expected_q.pop_front();
                if (got.status !== exp.status)
                    report_mismatch($sformatf("status %0d, want %0d", got.status, exp.status));
                if (got.top_priority !== exp.top_priority)
                    report_mismatch($sformatf("top_priority %0d, want %0d",
                                              got.top_priority, exp.top_priority));
                if (got.top_age !== exp.top_age)
                    report_mismatch($sformatf("top_age %0d, want %0d", got.top_age, exp.top_age));
                if (got.top_id !== exp.top_id)
                    report_mismatch($sformatf("top_id %h, want %h", got.top_id, exp.top_id));
                if (got.entry_count !== exp.entry_count)
                    report_mismatch($sformatf("entry_count %0d, want %0d",
                                              got.entry_count, exp.entry_count));
            end
        endtask
    endclass

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    mhpq_pkg::req_t s_data = '0;
    logic           m_valid;
    logic           m_ready = 1'b1;
    mhpq_pkg::rsp_t m_data;

    logic        rx_stall_en = 1'b0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;

    heap_scoreboard sb = new();

    max_heap_priority_queue u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver back-pressure in bursts
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1)
                m_ready <= 1'b1;
        end else if (rx_stall_en && $urandom_range(0, 9) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(1, 19);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_response(m_data);
    end

    task send_request(input mhpq_pkg::req_t r);
        s_data <= r;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_request(r);
    endtask

    task send_insert(input logic [7:0] p, input logic [6:0] a, input logic [15:0] id);
        mhpq_pkg::req_t r;
        r = '{action: mhpq_pkg::ACT_INSERT, priority_req: p, age: a, patient_id: id};
        send_request(r);
    endtask

    task send_remove();
        mhpq_pkg::req_t r;
        r = '{action: mhpq_pkg::ACT_REMOVE, priority_req: 8'hff, age: 7'h7f,
              patient_id: 16'hffff};
        send_request(r);
    endtask

    task idle_sender(input int unsigned n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // hold the sender until every queued response has been returned
    task wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0)
            @(negedge aclk);
        @(posedge aclk);
    endtask

    initial begin
        mhpq_pkg::req_t r;
        int unsigned    sent;
        int unsigned    phase;
        int unsigned    phase_len;
        int unsigned    ins_pct;
        bit             narrow;
        bit             idle_en;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed opening: empty remove, field extremes, ties
        send_remove();
        send_insert(8'd0, 7'd0, 16'h0000);
        send_insert(8'd255, 7'd127, 16'hffff);
        send_insert(8'd128, 7'h55, 16'haaaa);
        send_insert(8'd128, 7'h2a, 16'h5555);
        send_insert(8'd128, 7'd3, 16'h0003);
        send_insert(8'd255, 7'd1, 16'h0001);
        send_insert(8'd7, 7'd64, 16'h8000);
        send_insert(8'd128, 7'd9, 16'h0009);
        repeat (8) send_remove();
        send_remove();
        send_insert(8'd1, 7'd1, 16'h7fff);
        send_remove();
        wait_drained();

        rx_stall_en <= 1'b1;
        sent = 0;
        phase = 0;
        while (sent < RAND_ITEMS) begin
            unique case (phase % 3)
                0: ins_pct = 90;
                1: ins_pct = 12;
                default: ins_pct = 50;
            endcase
            narrow = ($urandom_range(0, 2) == 0);
            idle_en = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(70, 110);
            if (phase_len > RAND_ITEMS - sent)
                phase_len = RAND_ITEMS - sent;
            repeat (phase_len) begin
                if (sent >= QUIET_AFTER) begin
                    idle_en = 1'b0;
                    rx_stall_en <= 1'b0;
                end
                if (idle_en && $urandom_range(0, 7) == 0)
                    idle_sender($urandom_range(1, 19));
                r.action = ($urandom_range(1, 100) <= ins_pct) ? mhpq_pkg::ACT_INSERT
                                                               : mhpq_pkg::ACT_REMOVE;
                r.priority_req = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
                r.age = 7'($urandom_range(0, 127));
                r.patient_id = 16'($urandom_range(0, 65535));
                send_request(r);
                sent++;
                if (sent == RAND_ITEMS / 2)
                    wait_drained();
            end
            phase++;
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
